// ===== src/iron_tip_supervisor_top_macros.svh =====
// Assertion macros for the tip supervisor.
`ifndef IRON_TIP_SUPERVISOR_TOP_MACROS_SVH
`define IRON_TIP_SUPERVISOR_TOP_MACROS_SVH

`ifndef SYNTH
`define ITS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tip supervisor check failed");
`define ITS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tip supervisor check failed");
`else
`define ITS_ASSERT_NOW(lbl, ante, cons)
`define ITS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/its_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package its_pkg;

  localparam int COEF_W = 14;
  localparam logic [COEF_W-1:0] COEF_Q16 = 14'd12491;
  localparam int OFFSET_DEG = 11;
  localparam int DISCONNECT_DEG = 550;
  localparam logic [8:0] SET_MAX = 9'd450;
  localparam logic [8:0] SET_MIN = 9'd50;
  localparam logic [6:0] TICKS_PER_SEC = 7'd100;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WORK_SETPOINT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_TARGET = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIBERNATE_TICKS = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WINDOW = 4'd3;

  localparam logic [2:0] ST_NC = 3'd0;
  localparam logic [2:0] ST_OFF = 3'd1;
  localparam logic [2:0] ST_SLEEP = 3'd2;
  localparam logic [2:0] ST_HIB = 3'd3;
  localparam logic [2:0] ST_ACTIVE = 3'd4;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

`default_nettype wire

// ===== src/its_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface its_in_if #(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] adc_sample;
  logic                heat_enabled;
  logic                in_stand;

  modport source (output valid, output adc_sample, output heat_enabled,
                  output in_stand, input ready);
  modport sink (input valid, input adc_sample, input heat_enabled,
                input in_stand, output ready);
endinterface

`default_nettype wire

// ===== src/its_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface its_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] tip_state;
  logic [9:0] smoothed_degrees;
  logic [8:0] target_degrees;
  logic [9:0] seconds_to_hibernate;

  modport source (output valid, output tip_state, output smoothed_degrees,
                  output target_degrees, output seconds_to_hibernate, input ready);
  modport sink (input valid, input tip_state, input smoothed_degrees,
                input target_degrees, input seconds_to_hibernate, output ready);
endinterface

`default_nettype wire

// ===== src/its_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface its_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [its_pkg::CFG_IDX_W-1:0]    index;
  logic [its_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/its_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per step.
module its_div #(
  parameter int DVD_W = 16,
  parameter int DVS_W = 8
) (
  input  wire                    clk,
  input  wire its_pkg::div_ctl_t ctl,
  input  wire [DVD_W-1:0]        dividend,
  input  wire [DVS_W-1:0]        divisor,
  output logic [DVD_W-1:0]       quotient
);

  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVS_W:0]   shifted;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    shifted = {rem_r, quo_r[DVD_W-1]};
    if (ctl.load) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (ctl.step) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = DVS_W'(shifted - {1'b0, dvs_r});
        quo_nxt = {quo_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DVS_W-1:0];
        quo_nxt = {quo_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== src/iron_tip_supervisor_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Soldering tip supervisor. Each request carries one ADC sample with the enable and
// in-stand flags and yields one result: tip state, smoothed temperature in degrees,
// controller target and seconds left until hibernate. The sample is scaled by a
// bit-serial shift-add multiplier in S_MUL, then the moving-average step and the
// seconds count are divided in two restoring dividers running side by side in
// S_DIV. The result is registered in S_OUT, which holds while an earlier result
// still waits at the output register; a new request is taken only in S_IDLE. The
// input is taken again while a finished result still waits at the output register.
// Configuration writes are always ready and must be issued only while idle.

`include "iron_tip_supervisor_top_macros.svh"

module iron_tip_supervisor_top #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 6
) (
  input  wire              clk,
  input  wire              rst_n,
  its_in_if.sink           in_chan,
  its_out_if.source        out_chan,
  its_cfg_if.sink          cfg_chan
);

  localparam int PROD_W    = ADC_BITS + its_pkg::COEF_W;
  localparam int TEMP_W    = PROD_W + FRAC_BITS;
  localparam int DIV_STEPS = 16;
  localparam int STEPS     = (ADC_BITS > DIV_STEPS) ? ADC_BITS : DIV_STEPS;
  localparam int CNT_W     = $clog2(STEPS);
  localparam int SHIFT     = 16 - FRAC_BITS;
  localparam logic [TEMP_W-1:0] HALF   = TEMP_W'(1) << (15 - FRAC_BITS);
  localparam logic [TEMP_W-1:0] OFFSET = TEMP_W'(its_pkg::OFFSET_DEG) << FRAC_BITS;
  localparam logic [TEMP_W-1:0] DISC   = TEMP_W'(its_pkg::DISCONNECT_DEG) << FRAC_BITS;
  localparam logic [TEMP_W-1:0] SAT16  = TEMP_W'(16'hFFFF);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [8:0]  work_r, work_nxt;
  logic [8:0]  sleep_tgt_r, sleep_tgt_nxt;
  logic [15:0] hib_r, hib_nxt;
  logic [7:0]  win_r, win_nxt;

  logic [15:0] smooth_r, smooth_nxt;
  logic [2:0]  mode_r, mode_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [8:0]  target_r, target_nxt;

  logic [its_pkg::COEF_W-1:0] hi_r, hi_nxt;
  logic [ADC_BITS-1:0]        lo_r, lo_nxt;
  logic en_r, en_nxt;
  logic stand_r, stand_nxt;
  logic [15:0] temp_r, temp_nxt;
  logic neg_r, neg_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  o_state_r, o_state_nxt;
  logic [9:0]  o_deg_r, o_deg_nxt;
  logic [8:0]  o_tgt_r, o_tgt_nxt;
  logic [9:0]  o_secs_r, o_secs_nxt;

  logic [its_pkg::COEF_W:0] mul_sum;
  logic [TEMP_W-1:0] temp_full;
  logic [2:0]  sleep_ns;
  logic [8:0]  clamp_val;
  logic [15:0] deg_full;
  logic [15:0] mag_val;
  logic [15:0] left_val;
  logic [7:0]  win_eff;
  logic [15:0] avg_q;
  logic [15:0] secs_q;
  logic        in_acc;
  logic        cfg_acc;
  its_pkg::div_ctl_t div_ctl;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid && cfg_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign win_eff = (win_r == 8'd0) ? 8'd1 : win_r;
  assign div_ctl.load = (state_r == S_LOAD);
  assign div_ctl.step = (state_r == S_DIV);

  its_div #(.DVD_W(16), .DVS_W(8)) u_avg_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (mag_val),
    .divisor  (win_eff),
    .quotient (avg_q)
  );

  its_div #(.DVD_W(16), .DVS_W(7)) u_secs_div (
    .clk      (clk),
    .ctl      (div_ctl),
    .dividend (left_val),
    .divisor  (its_pkg::TICKS_PER_SEC),
    .quotient (secs_q)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    work_nxt      = work_r;
    sleep_tgt_nxt = sleep_tgt_r;
    hib_nxt       = hib_r;
    win_nxt       = win_r;
    smooth_nxt    = smooth_r;
    mode_nxt      = mode_r;
    elapsed_nxt   = elapsed_r;
    target_nxt    = target_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    en_nxt        = en_r;
    stand_nxt     = stand_r;
    temp_nxt      = temp_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    o_state_nxt   = o_state_r;
    o_deg_nxt     = o_deg_r;
    o_tgt_nxt     = o_tgt_r;
    o_secs_nxt    = o_secs_r;

    mul_sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, its_pkg::COEF_Q16} : '0);
    temp_full = ((TEMP_W'({hi_r, lo_r}) + HALF) >> SHIFT) + OFFSET;
    sleep_ns  = (elapsed_r >= hib_r) ? its_pkg::ST_HIB : its_pkg::ST_SLEEP;
    deg_full  = smooth_r >> FRAC_BITS;
    // divider operands, taken by the dividers in S_LOAD
    mag_val   = (temp_r < smooth_r) ? smooth_r - temp_r : temp_r - smooth_r;
    left_val  = (elapsed_r > hib_r) ? 16'd0 : hib_r - elapsed_r;

    if (cfg_chan.data[8:0] > its_pkg::SET_MAX) begin
      clamp_val = its_pkg::SET_MAX;
    end else if (cfg_chan.data[8:0] < its_pkg::SET_MIN) begin
      clamp_val = its_pkg::SET_MIN;
    end else begin
      clamp_val = cfg_chan.data[8:0];
    end

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          hi_nxt    = '0;
          lo_nxt    = in_chan.adc_sample;
          en_nxt    = in_chan.heat_enabled;
          stand_nxt = in_chan.in_stand;
          cnt_nxt   = CNT_W'(ADC_BITS - 1);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        hi_nxt = mul_sum[its_pkg::COEF_W:1];
        lo_nxt = {mul_sum[0], lo_r[ADC_BITS-1:1]};
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        temp_nxt = (temp_full > SAT16) ? 16'hFFFF : temp_full[15:0];
        priority if (temp_full > DISC) begin
          mode_nxt   = its_pkg::ST_NC;
          target_nxt = '0;
        end else if (!en_r) begin
          mode_nxt    = its_pkg::ST_OFF;
          target_nxt  = '0;
          elapsed_nxt = '0;
        end else if (stand_r) begin
          mode_nxt = sleep_ns;
          if (sleep_ns != mode_r) begin
            target_nxt = (sleep_ns == its_pkg::ST_SLEEP) ? sleep_tgt_r : 9'd0;
          end
          if (sleep_ns == its_pkg::ST_SLEEP && elapsed_r != 16'hFFFF) begin
            elapsed_nxt = elapsed_r + 16'd1;
          end
        end else begin
          if (mode_r != its_pkg::ST_ACTIVE) begin
            mode_nxt    = its_pkg::ST_ACTIVE;
            target_nxt  = work_r;
            elapsed_nxt = '0;
          end
        end
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        neg_nxt   = temp_r < smooth_r;
        cnt_nxt   = CNT_W'(DIV_STEPS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_UPD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_UPD: begin
        smooth_nxt = neg_r ? smooth_r - avg_q : smooth_r + avg_q;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          o_state_nxt   = mode_r;
          o_deg_nxt     = (deg_full > 16'd1023) ? 10'd1023 : deg_full[9:0];
          o_tgt_nxt     = target_r;
          o_secs_nxt    = secs_q[9:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_acc) begin
      priority if (cfg_chan.index == its_pkg::REG_WORK_SETPOINT) begin
        work_nxt = clamp_val;
        if (mode_r == its_pkg::ST_ACTIVE) begin
          target_nxt = clamp_val;
        end
      end else if (cfg_chan.index == its_pkg::REG_SLEEP_TARGET) begin
        sleep_tgt_nxt = cfg_chan.data[8:0];
      end else if (cfg_chan.index == its_pkg::REG_HIBERNATE_TICKS) begin
        hib_nxt = cfg_chan.data[15:0];
      end else if (cfg_chan.index == its_pkg::REG_SMOOTH_WINDOW) begin
        win_nxt = cfg_chan.data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      work_r      <= 9'd200;
      sleep_tgt_r <= 9'd80;
      hib_r       <= 16'd6000;
      win_r       <= 8'd10;
      smooth_r    <= '0;
      mode_r      <= its_pkg::ST_NC;
      elapsed_r   <= '0;
      target_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      work_r      <= work_nxt;
      sleep_tgt_r <= sleep_tgt_nxt;
      hib_r       <= hib_nxt;
      win_r       <= win_nxt;
      smooth_r    <= smooth_nxt;
      mode_r      <= mode_nxt;
      elapsed_r   <= elapsed_nxt;
      target_r    <= target_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    en_r     <= en_nxt;
    stand_r  <= stand_nxt;
    temp_r   <= temp_nxt;
    neg_r    <= neg_nxt;
    o_state_r <= o_state_nxt;
    o_deg_r  <= o_deg_nxt;
    o_tgt_r  <= o_tgt_nxt;
    o_secs_r <= o_secs_nxt;
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.tip_state            = o_state_r;
  assign out_chan.smoothed_degrees     = o_deg_r;
  assign out_chan.target_degrees       = o_tgt_r;
  assign out_chan.seconds_to_hibernate = o_secs_r;

  `ITS_ASSERT_NEXT(a_accept_starts_mul, in_acc, state_r == S_MUL)
  `ITS_ASSERT_NOW(a_active_target_range, mode_r == its_pkg::ST_ACTIVE,
                  target_r >= its_pkg::SET_MIN && target_r <= its_pkg::SET_MAX)
  `ITS_ASSERT_NOW(a_off_timer_clear, mode_r == its_pkg::ST_OFF, elapsed_r == 16'd0)

endmodule

`default_nettype wire

// ===== verif/iron_tip_monitor.sv =====
`timescale 1ns / 1ps

module iron_tip_monitor #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 6
) (
  input  logic clk,
  input  logic rst_n,
  its_in_if    in_mon,
  its_out_if   out_mon,
  its_cfg_if   cfg_mon,
  output int   mismatches,
  output int   reports_due
);
  import its_pkg::*;

  typedef struct packed {
    logic [2:0] tip_state;
    logic [9:0] smoothed_degrees;
    logic [8:0] target_degrees;
    logic [9:0] seconds_to_hibernate;
  } tip_report_t;

  logic [8:0]  work_sp;
  logic [8:0]  sleep_tgt;
  logic [15:0] hib_ticks;
  logic [7:0]  window;

  logic [15:0] smooth;
  logic [2:0]  tip_mode;
  logic [15:0] sleep_ticks;
  logic [8:0]  target;

  tip_report_t reports_q[$];

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    logic [8:0] sp;
    sp = val[8:0];
    case (idx)
      REG_WORK_SETPOINT: begin
        if (sp > SET_MAX) sp = SET_MAX;
        else if (sp < SET_MIN) sp = SET_MIN;
        work_sp = sp;
        if (tip_mode == ST_ACTIVE) target = work_sp;
      end
      REG_SLEEP_TARGET: sleep_tgt = val[8:0];
      REG_HIBERNATE_TICKS: hib_ticks = val[15:0];
      REG_SMOOTH_WINDOW: window = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic tip_report_t next_tip_report(input logic [ADC_BITS-1:0] adc,
                                                  input logic en, input logic stand);
    logic [31:0] temp;
    logic [31:0] temp_sat;
    logic [31:0] deg;
    int          win;
    int          diff;
    int          nxt;
    logic [2:0]  ns;
    tip_report_t r;
    temp = ((32'(adc) * 32'(COEF_Q16) + (32'd1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS))
           + (32'(OFFSET_DEG) << FRAC_BITS);
    temp_sat = (temp > 32'hFFFF) ? 32'hFFFF : temp;

    win = (window == 8'd0) ? 1 : int'(window);
    diff = int'(temp_sat) - int'(smooth);
    nxt = int'(smooth) + diff / win;
    smooth = nxt[15:0];

    if (temp > (32'(DISCONNECT_DEG) << FRAC_BITS)) begin
      tip_mode = ST_NC;
      target = 9'd0;
    end else if (!en) begin
      tip_mode = ST_OFF;
      target = 9'd0;
      sleep_ticks = 16'd0;
    end else if (stand) begin
      ns = (sleep_ticks >= hib_ticks) ? ST_HIB : ST_SLEEP;
      if (ns != tip_mode) begin
        target = (ns == ST_SLEEP) ? sleep_tgt : 9'd0;
        tip_mode = ns;
      end
      if (tip_mode == ST_SLEEP && sleep_ticks != 16'hFFFF) sleep_ticks = sleep_ticks + 16'd1;
    end else if (tip_mode != ST_ACTIVE) begin
      target = work_sp;
      tip_mode = ST_ACTIVE;
      sleep_ticks = 16'd0;
    end

    deg = 32'(smooth) >> FRAC_BITS;
    if (deg > 32'd1023) deg = 32'd1023;
    r.tip_state = tip_mode;
    r.smoothed_degrees = deg[9:0];
    r.target_degrees = target;
    if (sleep_ticks > hib_ticks) r.seconds_to_hibernate = 10'd0;
    else r.seconds_to_hibernate = 10'((32'(hib_ticks) - 32'(sleep_ticks)) / 32'(TICKS_PER_SEC));
    return r;
  endfunction

  always @(posedge clk) begin : watch
    tip_report_t want;
    int          bad;
    bad = 0;
    if (!rst_n) begin
      work_sp = 9'd200;
      sleep_tgt = 9'd80;
      hib_ticks = 16'd6000;
      window = 8'd10;
      smooth = 16'd0;
      tip_mode = ST_NC;
      sleep_ticks = 16'd0;
      target = 9'd0;
      reports_q.delete();
      mismatches <= 0;
      reports_due <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) apply_reg(cfg_mon.index, cfg_mon.data);
      if (out_mon.valid && out_mon.ready) begin
        if (reports_q.size() == 0) begin
          $error("result with no request outstanding: state %0d", out_mon.tip_state);
          bad = 1;
        end else begin
          want = reports_q.pop_front();
          if (out_mon.tip_state !== want.tip_state) begin
            $error("tip_state expected %0d actual %0d", want.tip_state, out_mon.tip_state);
            bad++;
          end
          if (out_mon.smoothed_degrees !== want.smoothed_degrees) begin
            $error("smoothed_degrees expected %0d actual %0d",
                   want.smoothed_degrees, out_mon.smoothed_degrees);
            bad++;
          end
          if (out_mon.target_degrees !== want.target_degrees) begin
            $error("target_degrees expected %0d actual %0d",
                   want.target_degrees, out_mon.target_degrees);
            bad++;
          end
          if (out_mon.seconds_to_hibernate !== want.seconds_to_hibernate) begin
            $error("seconds_to_hibernate expected %0d actual %0d",
                   want.seconds_to_hibernate, out_mon.seconds_to_hibernate);
            bad++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        reports_q.push_back(next_tip_report(in_mon.adc_sample, in_mon.heat_enabled,
                                            in_mon.in_stand));
      mismatches <= mismatches + bad;
      reports_due <= reports_q.size();
    end
  end

endmodule

// ===== verif/iron_tip_supervisor_top_test.sv =====
`timescale 1ns / 1ps

module iron_tip_supervisor_top_test;
  import its_pkg::*;

  localparam int ADC_W = 12;
  localparam int FRAC_W = 6;
  localparam int PHASE_SAMPLES = 630;

  logic clk;
  logic rst_n;
  int   send_idle;
  int   recv_idle;
  int   mismatches;
  int   reports_due;

  its_in_if #(.ADC_BITS(ADC_W)) in_chan ();
  its_out_if out_chan ();
  its_cfg_if cfg_chan ();

  iron_tip_supervisor_top #(
    .ADC_BITS(ADC_W),
    .FRAC_BITS(FRAC_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_chan(in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  iron_tip_monitor #(
    .ADC_BITS(ADC_W),
    .FRAC_BITS(FRAC_W)
  ) monitor (
    .clk(clk),
    .rst_n(rst_n),
    .in_mon(in_chan),
    .out_mon(out_chan),
    .cfg_mon(cfg_chan),
    .mismatches(mismatches),
    .reports_due(reports_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_sample(input logic [ADC_W-1:0] adc, input logic en, input logic stand);
    while ($urandom_range(99) < send_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.adc_sample <= adc;
    in_chan.heat_enabled <= en;
    in_chan.in_stand <= stand;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  // hold off requests until every report is back
  task automatic settle();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (reports_due != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data <= val;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_phase_regs(input int max_ticks, input int min_win, input int max_win);
    write_reg(REG_WORK_SETPOINT, 16'($urandom));
    write_reg(REG_SLEEP_TARGET, 16'($urandom));
    write_reg(REG_HIBERNATE_TICKS, 16'($urandom_range(max_ticks)));
    write_reg(REG_SMOOTH_WINDOW, 16'($urandom_range(max_win, min_win)));
  endtask

  task automatic retune();
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    idx = 4'($urandom_range(15));
    val = 16'($urandom);
    if (idx == REG_HIBERNATE_TICKS) val = 16'($urandom_range(60));
    else if (idx == REG_SMOOTH_WINDOW) val = {8'($urandom), 8'($urandom_range(20))};
    write_reg(idx, val);
  endtask

  // runs of steady flags around a noisy temperature level, with spikes and flag noise
  task automatic random_samples(input int count);
    int               run_left;
    logic             run_en;
    logic             run_stand;
    int               level;
    int               pick;
    int               a;
    logic [ADC_W-1:0] adc;
    logic             en;
    logic             stand;
    run_left = 0;
    run_en = 1'b0;
    run_stand = 1'b0;
    level = 0;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        pick = $urandom_range(99);
        run_en = (pick >= 12);
        run_stand = (pick >= 50);
        run_left = $urandom_range(60, 1);
        level = $urandom_range(2827);
      end
      run_left--;
      a = level + int'($urandom_range(64)) - 32;
      if (a < 0) a = 0;
      if (a > 4095) a = 4095;
      adc = a[ADC_W-1:0];
      en = run_en;
      stand = run_stand;
      pick = $urandom_range(99);
      if (pick < 8) adc = ADC_W'($urandom_range(4095));
      else if (pick < 11) begin
        en = 1'($urandom_range(1));
        stand = 1'($urandom_range(1));
      end
      if (i == count / 2) settle();
      if (i % 150 == 149) begin
        settle();
        retune();
      end
      send_sample(adc, en, stand);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    send_idle = 23;
    recv_idle = 69;
    in_chan.valid = 1'b0;
    in_chan.adc_sample = '0;
    in_chan.heat_enabled = 1'b0;
    in_chan.in_stand = 1'b0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = '0;
    cfg_chan.data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sample(12'd0, 1'b0, 1'b0);
    send_sample(12'hFFF, 1'b1, 1'b0);
    send_sample(12'd2827, 1'b1, 1'b0);  // hottest code still connected
    send_sample(12'd2828, 1'b1, 1'b1);  // first code read as disconnected
    send_sample(12'd1200, 1'b1, 1'b1);
    send_sample(12'd1200, 1'b1, 1'b1);
    send_sample(12'd1250, 1'b1, 1'b1);
    settle();
    write_reg(REG_HIBERNATE_TICKS, 16'd2);  // sleep count now past the limit
    send_sample(12'd1250, 1'b1, 1'b1);
    send_sample(12'd1300, 1'b1, 1'b0);
    settle();
    write_reg(REG_WORK_SETPOINT, 16'hFFFF);  // clamps high, retargets while active
    write_reg(REG_SLEEP_TARGET, 16'hFFFF);
    write_reg(REG_SMOOTH_WINDOW, 16'h0000);
    write_reg(4'd7, 16'h5A5A);
    write_reg(4'hF, 16'hFFFF);
    send_sample(12'd1300, 1'b1, 1'b1);
    send_sample(12'hFFF, 1'b0, 1'b1);
    send_sample(12'd100, 1'b0, 1'b1);
    send_sample(12'd100, 1'b1, 1'b0);
    settle();
    write_reg(REG_WORK_SETPOINT, 16'd0);
    write_reg(REG_HIBERNATE_TICKS, 16'd0);
    write_reg(REG_SMOOTH_WINDOW, 16'hFFFF);
    send_sample(12'd2000, 1'b1, 1'b1);
    send_sample(12'd0, 1'b1, 1'b0);
    settle();
    write_reg(REG_WORK_SETPOINT, 16'd49);
    write_reg(REG_WORK_SETPOINT, 16'd451);
    write_reg(REG_HIBERNATE_TICKS, 16'hFFFF);
    write_reg(REG_SLEEP_TARGET, 16'd0);
    write_reg(REG_SMOOTH_WINDOW, 16'd1);
    send_sample(12'd2000, 1'b1, 1'b1);
    send_sample(12'd0, 1'b1, 1'b1);
    send_sample(12'hFFF, 1'b1, 1'b1);
    send_sample(12'd2827, 1'b0, 1'b0);
    settle();

    set_phase_regs(40, 1, 16);
    random_samples(PHASE_SAMPLES);
    settle();

    send_idle = 69;
    recv_idle = 23;
    set_phase_regs(60, 200, 255);
    random_samples(PHASE_SAMPLES);
    settle();

    send_idle = 0;
    recv_idle = 0;
    set_phase_regs(25, 0, 8);
    random_samples(PHASE_SAMPLES);
    settle();
    repeat (40) @(posedge clk);

    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
